/* hw/rtl/wavhp_pkg.sv */
// wavhp_pkg: types and constants shared by the wav header parser
// standalone package, no dependencies

package wavhp_pkg;

  localparam int unsigned OFF_W = 25;

  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;

  localparam logic [31:0] SIZE_ALL_ONES = 32'hFFFF_FFFF;
  localparam logic [31:0] FMT_MIN_SIZE  = 32'd16;

  localparam int unsigned RIFF_TAG_END = 3;
  localparam int unsigned WAVE_TAG_END = 11;
  localparam int unsigned MIN_FILE_BYTES = 44;

  localparam logic [15:0] DEFAULT_CHANNELS = 16'd1;
  localparam logic [31:0] DEFAULT_RATE     = 32'd22050;
  localparam logic [15:0] DEFAULT_BITS     = 16'd16;

  // chunk header last byte indexes
  localparam logic [2:0] HDR_ID_END   = 3'd3;
  localparam logic [2:0] HDR_SIZE_END = 3'd7;

  // fmt body byte indexes
  localparam logic [3:0] FMT_CHAN_LO = 4'd2;
  localparam logic [3:0] FMT_CHAN_HI = 4'd3;
  localparam logic [3:0] FMT_RATE_B0 = 4'd4;
  localparam logic [3:0] FMT_RATE_B1 = 4'd5;
  localparam logic [3:0] FMT_RATE_B2 = 4'd6;
  localparam logic [3:0] FMT_RATE_B3 = 4'd7;
  localparam logic [3:0] FMT_BITS_LO = 4'd14;
  localparam logic [3:0] FMT_BITS_HI = 4'd15;

  typedef enum logic [3:0] {
    PH_RIFF = 4'b0001,
    PH_HDR  = 4'b0010,
    PH_BODY = 4'b0100,
    PH_DONE = 4'b1000
  } phase_t;

  typedef struct packed {
    logic              valid_res;
    logic [15:0]       channel_count;
    logic [31:0]       sample_rate;
    logic              is_sixteen_bit;
    logic [OFF_W-1:0]  payload_offset;
    logic [31:0]       payload_size;
  } result_t;

endpackage

/* hw/rtl/wavhp_chan_if.sv */
// wavhp_in_if, wavhp_out_if: valid/ready channels of the wav header parser
// depends on nothing

interface wavhp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       is_last;

  modport source (output valid, output byte_value, output is_last, input ready);
  modport sink (input valid, input byte_value, input is_last, output ready);
endinterface

interface wavhp_out_if;
  logic        valid;
  logic        ready;
  logic        valid_res;
  logic [15:0] channel_count;
  logic [31:0] sample_rate;
  logic        is_sixteen_bit;
  logic [24:0] payload_offset;
  logic [31:0] payload_size;

  modport source (output valid, output valid_res, output channel_count, output sample_rate,
                  output is_sixteen_bit, output payload_offset, output payload_size,
                  input ready);
  modport sink (input valid, input valid_res, input channel_count, input sample_rate,
                input is_sixteen_bit, input payload_offset, input payload_size,
                output ready);
endinterface

/* hw/rtl/wavhp_parse.sv */
// wavhp_parse: per-byte riff/wave chunk walker with its state registers
// depends on wavhp_pkg

module wavhp_parse #(
  parameter int unsigned MAX_FILE_BYTES = 16777216
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               take,
  input  logic [7:0]         byte_value,
  input  logic               is_last,
  output wavhp_pkg::result_t res
);

  localparam int unsigned POS_W = $clog2(MAX_FILE_BYTES + 1);
  localparam int unsigned SUM_W = ((POS_W > 32) ? POS_W : 32) + 1;
  localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_FILE_BYTES);

  wavhp_pkg::phase_t phase_r, phase_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             hok_r, hok_nxt;
  logic [31:0]      tag_r, tag_nxt;
  logic [31:0]      left_r, left_nxt;
  logic             is_fmt_r, is_fmt_nxt;
  logic             is_data_r, is_data_nxt;
  logic [2:0]       hdr_cnt_r, hdr_cnt_nxt;
  logic [4:0]       fmt_idx_r, fmt_idx_nxt;
  logic [15:0]      chan_r, chan_nxt;
  logic [31:0]      rate_r, rate_nxt;
  logic [15:0]      bits_r, bits_nxt;
  logic [POS_W-1:0] foff_r, foff_nxt;
  logic [31:0]      fsize_r, fsize_nxt;
  logic             fdata_r, fdata_nxt;

  logic [31:0]      size_w;
  logic [SUM_W-1:0] end_w;
  logic [SUM_W-1:0] off_ext;
  logic             ok;

  assign size_w = {byte_value, tag_r[31:8]};

  always_comb begin
    phase_nxt   = phase_r;
    pos_nxt     = (pos_r >= MAX_POS) ? MAX_POS : pos_r + POS_W'(1);
    hok_nxt     = hok_r;
    tag_nxt     = tag_r;
    left_nxt    = left_r;
    is_fmt_nxt  = is_fmt_r;
    is_data_nxt = is_data_r;
    hdr_cnt_nxt = hdr_cnt_r;
    fmt_idx_nxt = fmt_idx_r;
    chan_nxt    = chan_r;
    rate_nxt    = rate_r;
    bits_nxt    = bits_r;
    foff_nxt    = foff_r;
    fsize_nxt   = fsize_r;
    fdata_nxt   = fdata_r;

    case (phase_r)
      wavhp_pkg::PH_RIFF: begin
        tag_nxt = {tag_r[23:0], byte_value};
        if (pos_r == POS_W'(wavhp_pkg::RIFF_TAG_END) && tag_nxt != wavhp_pkg::TAG_RIFF) begin
          hok_nxt = 1'b0;
        end
        if (pos_r == POS_W'(wavhp_pkg::WAVE_TAG_END)) begin
          if (tag_nxt != wavhp_pkg::TAG_WAVE) begin
            hok_nxt = 1'b0;
          end
          tag_nxt     = '0;
          hdr_cnt_nxt = '0;
          phase_nxt   = wavhp_pkg::PH_HDR;
        end
      end
      wavhp_pkg::PH_HDR: begin
        hdr_cnt_nxt = hdr_cnt_r + 3'd1;
        if (!hdr_cnt_r[2]) begin
          tag_nxt = {tag_r[23:0], byte_value};
          if (hdr_cnt_r == wavhp_pkg::HDR_ID_END) begin
            is_fmt_nxt  = (tag_nxt == wavhp_pkg::TAG_FMT);
            is_data_nxt = (tag_nxt == wavhp_pkg::TAG_DATA);
            tag_nxt     = '0;
          end
        end else begin
          tag_nxt = size_w;
        end
        if (hdr_cnt_r == wavhp_pkg::HDR_SIZE_END) begin
          tag_nxt = '0;
          if (is_data_r) begin
            fdata_nxt = 1'b1;
            foff_nxt  = pos_nxt;
            fsize_nxt = size_w;
            phase_nxt = wavhp_pkg::PH_DONE;
          end else begin
            if (is_fmt_r && size_w < wavhp_pkg::FMT_MIN_SIZE) begin
              hok_nxt = 1'b0;
            end
            if (size_w == wavhp_pkg::SIZE_ALL_ONES) begin
              left_nxt = wavhp_pkg::SIZE_ALL_ONES;
            end else begin
              left_nxt = size_w + {31'd0, size_w[0]};
            end
            fmt_idx_nxt = '0;
            phase_nxt   = (left_nxt != '0) ? wavhp_pkg::PH_BODY : wavhp_pkg::PH_HDR;
          end
        end
      end
      wavhp_pkg::PH_BODY: begin
        if (is_fmt_r && !fmt_idx_r[4]) begin
          fmt_idx_nxt = fmt_idx_r + 5'd1;
          case (fmt_idx_r[3:0])
            wavhp_pkg::FMT_CHAN_LO: chan_nxt[7:0]   = byte_value;
            wavhp_pkg::FMT_CHAN_HI: chan_nxt[15:8]  = byte_value;
            wavhp_pkg::FMT_RATE_B0: rate_nxt[7:0]   = byte_value;
            wavhp_pkg::FMT_RATE_B1: rate_nxt[15:8]  = byte_value;
            wavhp_pkg::FMT_RATE_B2: rate_nxt[23:16] = byte_value;
            wavhp_pkg::FMT_RATE_B3: rate_nxt[31:24] = byte_value;
            wavhp_pkg::FMT_BITS_LO: bits_nxt[7:0]   = byte_value;
            wavhp_pkg::FMT_BITS_HI: bits_nxt[15:8]  = byte_value;
            default: ;
          endcase
        end
        left_nxt = left_r - 32'd1;
        if (left_r == 32'd1) begin
          hdr_cnt_nxt = '0;
          phase_nxt   = wavhp_pkg::PH_HDR;
        end
      end
      wavhp_pkg::PH_DONE: ;
      default: phase_nxt = wavhp_pkg::PH_RIFF;
    endcase
  end

  // result of the file if this byte is the last one
  assign off_ext = SUM_W'(foff_nxt);
  assign end_w   = off_ext + SUM_W'(fsize_nxt);
  assign ok = hok_nxt && (pos_nxt >= POS_W'(wavhp_pkg::MIN_FILE_BYTES)) && fdata_nxt &&
              (fsize_nxt != '0) && (end_w <= SUM_W'(pos_nxt));

  always_comb begin
    res.valid_res      = ok;
    res.channel_count  = ok ? chan_nxt : '0;
    res.sample_rate    = ok ? rate_nxt : '0;
    res.is_sixteen_bit = ok && (bits_nxt == wavhp_pkg::DEFAULT_BITS);
    res.payload_offset = ok ? off_ext[wavhp_pkg::OFF_W-1:0] : '0;
    res.payload_size   = ok ? fsize_nxt : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (take && is_last)) begin
      phase_r   <= wavhp_pkg::PH_RIFF;
      pos_r     <= '0;
      hok_r     <= 1'b1;
      tag_r     <= '0;
      left_r    <= '0;
      is_fmt_r  <= 1'b0;
      is_data_r <= 1'b0;
      hdr_cnt_r <= '0;
      fmt_idx_r <= '0;
      chan_r    <= wavhp_pkg::DEFAULT_CHANNELS;
      rate_r    <= wavhp_pkg::DEFAULT_RATE;
      bits_r    <= wavhp_pkg::DEFAULT_BITS;
      foff_r    <= '0;
      fsize_r   <= '0;
      fdata_r   <= 1'b0;
    end else if (take) begin
      phase_r   <= phase_nxt;
      pos_r     <= pos_nxt;
      hok_r     <= hok_nxt;
      tag_r     <= tag_nxt;
      left_r    <= left_nxt;
      is_fmt_r  <= is_fmt_nxt;
      is_data_r <= is_data_nxt;
      hdr_cnt_r <= hdr_cnt_nxt;
      fmt_idx_r <= fmt_idx_nxt;
      chan_r    <= chan_nxt;
      rate_r    <= rate_nxt;
      bits_r    <= bits_nxt;
      foff_r    <= foff_nxt;
      fsize_r   <= fsize_nxt;
      fdata_r   <= fdata_nxt;
    end
  end

endmodule

/* hw/rtl/wav_header_chunk_parser_unit.sv */
// wav_header_chunk_parser_unit: top level of the riff/wave header parser
// depends on wavhp_pkg, wavhp_chan_if.sv, wavhp_parse.sv
//
//   channel  dir  transaction     payload
//   in_ch    in   one file byte   byte_value, is_last
//   out_ch   out  one result      valid_res .. payload_size
//
// one byte per cycle unless stalled; results show the cycle after the last byte
// the chunk walker state and the result register are the only pipeline stages
// a held result stalls input only when the next last byte would overwrite it
// synchronous active-low reset returns the walker to the riff tag phase

module wav_header_chunk_parser_unit #(
  parameter int unsigned MAX_FILE_BYTES = 16777216
) (
  input  logic        clk,
  input  logic        rst_n,
  wavhp_in_if.sink    in_ch,
  wavhp_out_if.source out_ch
);

  logic               take;
  logic               out_valid_r;
  wavhp_pkg::result_t res_w;
  wavhp_pkg::result_t res_r;

  // bytes that are not the last never touch the result register
  assign in_ch.ready = !out_valid_r || out_ch.ready || !in_ch.is_last;
  assign take        = in_ch.valid && in_ch.ready;

  wavhp_parse #(
    .MAX_FILE_BYTES(MAX_FILE_BYTES)
  ) u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .byte_value(in_ch.byte_value),
    .is_last   (in_ch.is_last),
    .res       (res_w)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take && in_ch.is_last) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && in_ch.is_last) begin
      res_r <= res_w;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.valid_res      = res_r.valid_res;
  assign out_ch.channel_count  = res_r.channel_count;
  assign out_ch.sample_rate    = res_r.sample_rate;
  assign out_ch.is_sixteen_bit = res_r.is_sixteen_bit;
  assign out_ch.payload_offset = res_r.payload_offset;
  assign out_ch.payload_size   = res_r.payload_size;

endmodule

/* hw/rtl/wavhp_chk.sv */
// wavhp_chk: port-level checks of the wav header parser, bound to the top level
// depends on wav_header_chunk_parser_unit.sv

module wavhp_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_is_last,
  input logic        out_valid,
  input logic        out_ready,
  input logic        valid_res,
  input logic [15:0] channel_count,
  input logic [31:0] sample_rate,
  input logic        is_sixteen_bit,
  input logic [24:0] payload_offset,
  input logic [31:0] payload_size
);

  logic last_take;
  assign last_take = in_valid && in_ready && in_is_last;

  // a result waiting for its taker stays
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // every last byte yields a result next cycle
  a_last_result: assert property (@(posedge clk) disable iff (!rst_n)
    last_take |=> out_valid)
    else $error("no result after last byte");

  // a taken result without a new last byte leaves the channel empty
  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !last_take |=> !out_valid)
    else $error("result repeated");

  // a rejected file reports all fields zero
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !valid_res |-> channel_count == '0 && sample_rate == '0 &&
      !is_sixteen_bit && payload_offset == '0 && payload_size == '0)
    else $error("invalid result carries data");

  // an accepted file has a nonempty payload past the riff and chunk headers
  a_valid_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && valid_res |-> payload_size != '0 && payload_offset >= 25'd20)
    else $error("accepted result out of shape");

endmodule

bind wav_header_chunk_parser_unit wavhp_chk u_wavhp_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .in_is_last    (in_ch.is_last),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .valid_res     (out_ch.valid_res),
  .channel_count (out_ch.channel_count),
  .sample_rate   (out_ch.sample_rate),
  .is_sixteen_bit(out_ch.is_sixteen_bit),
  .payload_offset(out_ch.payload_offset),
  .payload_size  (out_ch.payload_size)
);
